### design/ipsp_pkg.sv
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants for the IPS patch stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [23:0] EOF_MARK    = 24'h454F46;  // "EOF"
  localparam logic [2:0]  HDR_LAST    = 3'd4;        // "PATCH" is five bytes
  localparam logic [2:0]  OFFSET_LAST = 3'd2;
  localparam logic [2:0]  LENGTH_LAST = 3'd1;
  localparam logic [2:0]  TRAIL_LAST  = 3'd2;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_OFFSET    = 4'd1,
    PH_LENGTH    = 4'd2,
    PH_LITERAL   = 4'd3,
    PH_RLE_COUNT = 4'd4,
    PH_RLE_VALUE = 4'd5,
    PH_TRAILER   = 4'd6,
    PH_DONE      = 4'd7,
    PH_HALTED    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_END     = 3'd2,
    CMD_TRUNC   = 3'd3,
    CMD_HDR_ERR = 3'd4
  } cmd_kind_t;

  // Compact command; a truncate carries its size in addr[23:0].
  typedef struct packed {
    cmd_kind_t   kind;
    logic [24:0] addr;
    logic [7:0]  value;
    logic [15:0] count;
  } cmd_t;

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h50;  // P
      3'd1:    ch = 8'h41;  // A
      3'd2:    ch = 8'h54;  // T
      3'd3:    ch = 8'h43;  // C
      3'd4:    ch = 8'h48;  // H
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### design/ipsp_front.sv
// ----------------------------------------------------------------------------
// ipsp_front
// Byte parser: tracks header, record fields and trailer, and produces at
// most one command per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_front
  import ipsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] patch_byte,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  phase_t      phase, phase_next;
  logic [2:0]  idx, idx_next;
  logic [23:0] record_offset, record_offset_next;
  logic [15:0] record_length, record_length_next;
  logic [24:0] write_address, write_address_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [23:0] trailer_size, trailer_size_next;

  logic [23:0] offset_shift;
  logic [15:0] length_shift;
  logic [23:0] trailer_shift;
  logic [15:0] remain_dec;

  assign offset_shift  = {record_offset[15:0], patch_byte};
  assign length_shift  = {record_length[7:0], patch_byte};
  assign trailer_shift = {trailer_size[15:0], patch_byte};
  assign remain_dec    = bytes_remaining - 16'd1;

  // next state
  always_comb begin
    phase_next           = phase;
    idx_next             = idx;
    record_offset_next   = record_offset;
    record_length_next   = record_length;
    write_address_next   = write_address;
    bytes_remaining_next = bytes_remaining;
    trailer_size_next    = trailer_size;
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (patch_byte != header_byte(idx)) begin
            phase_next = PH_HALTED;
          end else if (idx == HDR_LAST) begin
            idx_next           = '0;
            record_offset_next = '0;
            phase_next         = PH_OFFSET;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        PH_OFFSET: begin
          record_offset_next = offset_shift;
          if (idx == OFFSET_LAST) begin
            idx_next = '0;
            if (offset_shift == EOF_MARK) begin
              trailer_size_next = '0;
              phase_next        = PH_TRAILER;
            end else begin
              record_length_next = '0;
              phase_next         = PH_LENGTH;
            end
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        PH_LENGTH: begin
          record_length_next = length_shift;
          if (idx == LENGTH_LAST) begin
            idx_next = '0;
            if (length_shift != '0) begin
              bytes_remaining_next = length_shift;
              write_address_next   = {1'b0, record_offset};
              phase_next           = PH_LITERAL;
            end else begin
              phase_next = PH_RLE_COUNT;
            end
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        PH_LITERAL: begin
          write_address_next   = write_address + 25'd1;
          bytes_remaining_next = remain_dec;
          if (remain_dec == '0) begin
            idx_next           = '0;
            record_offset_next = '0;
            phase_next         = PH_OFFSET;
          end
        end
        PH_RLE_COUNT: begin
          record_length_next = length_shift;
          if (idx == LENGTH_LAST) begin
            idx_next   = '0;
            phase_next = PH_RLE_VALUE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        PH_RLE_VALUE: begin
          idx_next           = '0;
          record_offset_next = '0;
          phase_next         = PH_OFFSET;
        end
        PH_TRAILER: begin
          trailer_size_next = trailer_shift;
          if (idx == TRAIL_LAST) begin
            idx_next   = '0;
            phase_next = PH_DONE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command output
  always_comb begin
    cmd_valid  = 1'b0;
    cmd.kind   = CMD_WRITE;
    cmd.addr   = '0;
    cmd.value  = '0;
    cmd.count  = '0;
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (patch_byte != header_byte(idx)) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_HDR_ERR;
          end
        end
        PH_OFFSET: begin
          if (idx == OFFSET_LAST && offset_shift == EOF_MARK) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_END;
          end
        end
        PH_LITERAL: begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_WRITE;
          cmd.addr  = write_address;
          cmd.value = patch_byte;
        end
        PH_RLE_VALUE: begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_FILL;
          cmd.addr  = {1'b0, record_offset};
          cmd.value = patch_byte;
          cmd.count = record_length;
        end
        PH_TRAILER: begin
          if (idx == TRAIL_LAST) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_TRUNC;
            cmd.addr  = {1'b0, trailer_shift};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      idx             <= '0;
      record_offset   <= '0;
      record_length   <= '0;
      write_address   <= '0;
      bytes_remaining <= '0;
      trailer_size    <= '0;
    end else begin
      phase           <= phase_next;
      idx             <= idx_next;
      record_offset   <= record_offset_next;
      record_length   <= record_length_next;
      write_address   <= write_address_next;
      bytes_remaining <= bytes_remaining_next;
      trailer_size    <= trailer_size_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALTED |=> phase == PH_HALTED)
    else $error("parser left halted state");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("parser left done state");

  a_header_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && phase == PH_HEADER |-> cmd.kind == CMD_HDR_ERR)
    else $error("header phase produced a non-error command");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= HDR_LAST)
    else $error("field byte index out of range");

endmodule

`default_nettype wire

### design/ipsp_cmd_queue.sv
// ----------------------------------------------------------------------------
// ipsp_cmd_queue
// Small command queue between the parser and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_cmd_queue
  import ipsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      full,
  output logic      empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count over depth");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + QUEUE_CW'(1))
    else $error("queue count did not follow a lone push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    !full |-> wr_ptr == rd_ptr + count[QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### design/ips_patch_stream_parser_top.sv
// ----------------------------------------------------------------------------
// ips_patch_stream_parser_top
// IPS patch parser: patch bytes in, memory write commands out.
//
// Input channel: push/full with patch_byte, one stream byte per request.
// Output channel: empty/pop; the oldest command sits on command_kind,
// target_address, data_value, run_count and new_size while empty is low.
// A byte is parsed in the cycle it is accepted; a command it causes is in
// a four-entry queue and is on the output in the cycle after if the queue was empty.
// Throughput is one byte per cycle as long as the receiver keeps popping;
// the queue depth sets how far the receiver may fall behind before full
// rises and input stalls. Bytes that make no command still wait on full.
// After a header error or a truncate every further byte is taken and
// dropped. Reset (rst, synchronous) clears the parser and empties the
// queue; the block takes bytes in the cycle after reset falls.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_patch_stream_parser_top
  import ipsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  patch_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       command_kind,
  output logic [24:0]      target_address,
  output logic [7:0]       data_value,
  output logic [15:0]      run_count,
  output logic [23:0]      new_size
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic is_trunc;

  assign accept = push && !full;

  ipsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .patch_byte (patch_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_in)
  );

  ipsp_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd_in),
    .rd_en   (pop),
    .rd_data (cmd_out),
    .full    (full),
    .empty   (empty)
  );

  // truncate size travels in the address slot
  assign is_trunc       = (cmd_out.kind == CMD_TRUNC);
  assign command_kind   = cmd_out.kind;
  assign target_address = is_trunc ? '0 : cmd_out.addr;
  assign new_size       = is_trunc ? cmd_out.addr[23:0] : '0;
  assign data_value     = cmd_out.value;
  assign run_count      = cmd_out.count;

endmodule

`default_nettype wire

### dv/ipsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsp_checker
// Watches both queue channels of the IPS patch parser, predicts the commands
// from the accepted patch bytes and compares them in order with the commands
// popped from the block.
// ----------------------------------------------------------------------------

module ipsp_checker
  import ipsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  patch_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  command_kind,
  input  logic [24:0] target_address,
  input  logic [7:0]  data_value,
  input  logic [15:0] run_count,
  input  logic [23:0] new_size,
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          writes_seen,
  output int          fills_seen
);

  typedef struct packed {
    cmd_kind_t   kind;
    logic [24:0] addr;
    logic [7:0]  value;
    logic [15:0] count;
    logic [23:0] size;
  } patch_cmd_t;

  localparam logic [39:0] MAGIC = "PATCH";

  phase_t      phase;
  logic [2:0]  fidx;
  logic [23:0] rec_off;
  logic [15:0] rec_len;
  logic [24:0] wr_addr;
  logic [15:0] left_cnt;
  logic [23:0] trail;
  patch_cmd_t  cmd_fifo[$];

  // Advance the parser state by one byte; queue the command it makes, if any.
  function automatic void decode_patch_byte(input logic [7:0] b);
    patch_cmd_t c;
    c = '0;
    case (phase)
      PH_HEADER: begin
        if (b != MAGIC[8*(4 - int'(fidx)) +: 8]) begin
          phase = PH_HALTED;
          c.kind = CMD_HDR_ERR;
          cmd_fifo.push_back(c);
        end else if (fidx == 3'd4) begin
          fidx = '0;
          rec_off = '0;
          phase = PH_OFFSET;
        end else begin
          fidx++;
        end
      end
      PH_OFFSET: begin
        rec_off = {rec_off[15:0], b};
        if (fidx == 3'd2) begin
          fidx = '0;
          if (rec_off == EOF_MARK) begin
            trail = '0;
            phase = PH_TRAILER;
            c.kind = CMD_END;
            cmd_fifo.push_back(c);
          end else begin
            rec_len = '0;
            phase = PH_LENGTH;
          end
        end else begin
          fidx++;
        end
      end
      PH_LENGTH, PH_RLE_COUNT: begin
        rec_len = {rec_len[7:0], b};
        if (fidx == 3'd1) begin
          fidx = '0;
          if (phase == PH_RLE_COUNT) begin
            phase = PH_RLE_VALUE;
          end else if (rec_len != 0) begin
            left_cnt = rec_len;
            wr_addr = {1'b0, rec_off};
            phase = PH_LITERAL;
          end else begin
            phase = PH_RLE_COUNT;
          end
        end else begin
          fidx++;
        end
      end
      PH_LITERAL: begin
        c.kind = CMD_WRITE;
        c.addr = wr_addr;
        c.value = b;
        cmd_fifo.push_back(c);
        wr_addr = wr_addr + 25'd1;
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 0) begin
          fidx = '0;
          rec_off = '0;
          phase = PH_OFFSET;
        end
      end
      PH_RLE_VALUE: begin
        c.kind = CMD_FILL;
        c.addr = {1'b0, rec_off};
        c.value = b;
        c.count = rec_len;
        cmd_fifo.push_back(c);
        fidx = '0;
        rec_off = '0;
        phase = PH_OFFSET;
      end
      PH_TRAILER: begin
        trail = {trail[15:0], b};
        if (fidx == 3'd2) begin
          fidx = '0;
          phase = PH_DONE;
          c.kind = CMD_TRUNC;
          c.size = trail;
          cmd_fifo.push_back(c);
        end else begin
          fidx++;
        end
      end
      default: ;  // done or halted: bytes are dropped
    endcase
  endfunction

  always @(posedge clk) begin : watch
    patch_cmd_t got;
    patch_cmd_t want;
    if (rst) begin
      phase = PH_HEADER;
      fidx = '0;
      rec_off = '0;
      rec_len = '0;
      wr_addr = '0;
      left_cnt = '0;
      trail = '0;
      cmd_fifo.delete();
    end else begin
      if (pop && !empty) begin
        got.kind = cmd_kind_t'(command_kind);
        got.addr = target_address;
        got.value = data_value;
        got.count = run_count;
        got.size = new_size;
        checked++;
        if (got.kind == CMD_WRITE) writes_seen++;
        if (got.kind == CMD_FILL) fills_seen++;
        if (cmd_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected command kind=%0d addr=%h val=%h cnt=%h size=%h",
                     $realtime, got.kind, got.addr, got.value, got.count, got.size);
        end else begin
          want = cmd_fifo.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: command mismatch exp kind=%0d addr=%h val=%h cnt=%h size=%h",
                       $realtime, want.kind, want.addr, want.value, want.count, want.size);
              $display("%0t:                  got kind=%0d addr=%h val=%h cnt=%h size=%h",
                       $realtime, got.kind, got.addr, got.value, got.count, got.size);
            end
          end
        end
      end
      if (push && !full) decode_patch_byte(patch_byte);
    end
    outstanding = cmd_fifo.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the IPS patch parser one well-formed patch: header, directed edge
// records, about 500 bytes of random literal and RLE records, the end marker
// and a truncate trailer, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module testbench;
  import ipsp_pkg::*;

  localparam int LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  patch_byte;
  logic        empty;
  logic        pop;
  logic [2:0]  command_kind;
  logic [24:0] target_address;
  logic [7:0]  data_value;
  logic [15:0] run_count;
  logic [23:0] new_size;

  int mismatches;
  int outstanding;
  int checked;
  int writes_seen;
  int fills_seen;

  int cycle_cnt;
  int bytes_sent;
  int burst_left;
  int pop_level;
  int pop_hold;
  bit drain;

  ips_patch_stream_parser_top dut (
    .clk, .rst, .push, .full, .patch_byte, .empty, .pop,
    .command_kind, .target_address, .data_value, .run_count, .new_size
  );

  ipsp_checker chk (
    .clk, .rst, .push, .full, .patch_byte, .empty, .pop,
    .command_kind, .target_address, .data_value, .run_count, .new_size,
    .mismatches, .outstanding, .checked, .writes_seen, .fills_seen
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: pop rate is drawn at random and held for a random span, from never to always.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (drain) begin
        pop = 1'b1;
      end else begin
        if (pop_hold == 0) begin
          pop_level = $urandom_range(0, 8);
          pop_hold = $urandom_range(8, 64);
        end
        pop_hold--;
        pop = ($urandom_range(1, 8) <= pop_level);
      end
    end
  end

  // One request; bursts of random length with random gaps between them.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    push = 1'b1;
    patch_byte = b;
    do @(posedge clk); while (full);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic put_field24(input logic [23:0] v);
    put_byte(v[23:16]);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic put_literal(input logic [23:0] off, input logic [15:0] len);
    put_field24(off);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       put_byte(8'h00);
        1:       put_byte(8'hFF);
        default: put_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic put_fill(input logic [23:0] off, input logic [15:0] cnt,
                          input logic [7:0] val);
    put_field24(off);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(cnt[15:8]);
    put_byte(cnt[7:0]);
    put_byte(val);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [23:0] off;
    logic [15:0] cnt;
    bit          paused;
    int          pick;
    rst = 1'b1;
    push = 1'b0;
    patch_byte = 8'h00;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // header, then a literal that crosses into the 25th address bit
    put_byte("P");
    put_byte("A");
    put_byte("T");
    put_byte("C");
    put_byte("H");
    put_field24(24'hFFFFFF);
    put_byte(8'h00);
    put_byte(8'h02);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_fill(24'h000000, 16'hFFFF, 8'hAA);
    put_fill(24'h123456, 16'h0000, 8'h55);
    wait_drained();

    while (bytes_sent < 500) begin
      do begin
        if ($urandom_range(0, 7) == 0) off = 24'hFFFFFF - 24'($urandom_range(0, 15));
        else off = 24'($urandom_range(0, 24'hFFFFFF));
      end while (off == EOF_MARK);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        put_literal(off, 16'($urandom_range(1, 8)));
      end else if (pick == 6) begin
        put_literal(off, 16'($urandom_range(9, 40)));
      end else begin
        cnt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4))
                                          : 16'($urandom_range(0, 65535));
        put_fill(off, cnt, 8'($urandom_range(0, 255)));
      end
      if (!paused && bytes_sent >= 200) begin
        // let the queue run dry, then one record with a nonzero high length byte
        wait_drained();
        put_literal(off, 16'h0104);
        paused = 1'b1;
      end
    end

    put_field24(EOF_MARK);
    put_field24(24'($urandom_range(0, 24'hFFFFFF)));
    // ignored after the truncate
    repeat (4) put_byte(8'($urandom_range(0, 255)));
    push = 1'b0;

    drain = 1'b1;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d patch bytes: header, %0d literal writes, %0d fills, end and truncate.",
             bytes_sent, writes_seen, fills_seen);
    $display("Checked %0d commands, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && outstanding == 0 && empty) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/ipsp_pkg.sv
design/ipsp_front.sv
design/ipsp_cmd_queue.sv
design/ips_patch_stream_parser_top.sv
dv/ipsp_checker.sv
dv/testbench.sv
